// File: rtl/ebh_pkg.sv
// shared constants, request codes and the store request struct for the
// exponential bucket histogram; no dependencies
package ebh_pkg;

    localparam int MAX_BUCKETS = 64;
    localparam int IDX_W       = $clog2(MAX_BUCKETS);
    localparam int HI_W        = IDX_W + 1;
    localparam int ACT_W       = 7;
    localparam int VAL_W       = 31;
    localparam int CNT_W       = 32;
    localparam int SUM_W       = 63;
    localparam int SQ_W        = 2 * VAL_W;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [ACT_W-1:0] ACT_MIN = ACT_W'(2);
    localparam logic [ACT_W-1:0] ACT_TOP = ACT_W'(MAX_BUCKETS);

    typedef enum logic [1:0] {
        REQ_ADD   = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_READ  = 2'd2,
        REQ_UNDEF = 2'd3
    } t_req;

    // one access to the bucket store per cycle
    typedef struct packed {
        logic             bnd_we;
        logic [IDX_W-1:0] bnd_addr;
        logic [VAL_W-1:0] bnd_wdata;
        logic             cnt_we;
        logic [IDX_W-1:0] cnt_addr;
        logic [CNT_W-1:0] cnt_wdata;
    } t_mem_req;

endpackage

// File: rtl/ebh_store.sv
// bucket store: boundary memory and count memory with per-entry valid bits
// depends on ebh_pkg
module ebh_store (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  ebh_pkg::t_mem_req       i_req,
    output logic [ebh_pkg::VAL_W-1:0] o_bnd_rdata,
    output logic [ebh_pkg::CNT_W-1:0] o_cnt_rdata
);
    import ebh_pkg::*;

    logic [VAL_W-1:0]       r_bnd_mem [MAX_BUCKETS];
    logic [CNT_W-1:0]       r_cnt_mem [MAX_BUCKETS];
    logic [MAX_BUCKETS-1:0] r_cnt_vld;
    logic [VAL_W-1:0]       r_bnd_raw;
    logic                   r_bnd_zero;
    logic [CNT_W-1:0]       r_cnt_raw;
    logic                   r_cnt_hit;

    // boundary memory, bucket 0 always reads as zero
    always_ff @(posedge i_clk) begin
        if (i_req.bnd_we) begin
            r_bnd_mem[i_req.bnd_addr] <= i_req.bnd_wdata;
        end
        r_bnd_raw  <= r_bnd_mem[i_req.bnd_addr];
        r_bnd_zero <= (i_req.bnd_addr == '0);
    end

    // count memory, payload only
    always_ff @(posedge i_clk) begin
        if (i_req.cnt_we) begin
            r_cnt_mem[i_req.cnt_addr] <= i_req.cnt_wdata;
        end
        r_cnt_raw <= r_cnt_mem[i_req.cnt_addr];
    end

    // valid bits stand in for clearing the counts at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld <= '0;
            r_cnt_hit <= 1'b0;
        end else begin
            if (i_req.cnt_we) begin
                r_cnt_vld[i_req.cnt_addr] <= 1'b1;
            end
            r_cnt_hit <= r_cnt_vld[i_req.cnt_addr];
        end
    end

    assign o_bnd_rdata = r_bnd_zero ? '0 : r_bnd_raw;
    assign o_cnt_rdata = r_cnt_hit ? r_cnt_raw : '0;

endmodule

// File: rtl/exponential_bucket_histogram.sv
// exponential bucket histogram: sequencer, shared search compare, sum unit
// depends on ebh_pkg and ebh_store
//
//  channel   dir  handshake                     contents
//  s_axis    in   s_axis_tvalid/s_axis_tready   request beat, kind in tuser
//  m_axis    out  m_axis_tvalid/m_axis_tready   result beat, status in tuser
//  cfg       in   i_cfg_valid/o_cfg_ready       active bucket count
//
// add: binary search of k compares (6 for 64 buckets); each compare takes a
// boundary memory read (S_SADDR) and a compare (S_SCMP), then S_RD, S_UPD,
// S_SUM1, S_SUM2, S_OUT. write/read: S_RD, S_UPD, S_OUT; rejected: S_OUT.
// one request at a time; s_axis_tready is high only when idle, and a result
// waits in the output register while the next request is accepted.
// synchronous active-low reset clears counts (valid bits), sums and control.
module exponential_bucket_histogram (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // sample_value[31:0], bucket_select[37:32], boundary_value[68:38], pad
    input  logic [71:0]  s_axis_tdata,
    // req_type[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // found_bucket[5:0], bucket_total[37:6], bucket_lower[68:38],
    // value_sum[131:69], sumsq[194:132], pad
    output logic [199:0] m_axis_tdata,
    // status[0]
    output logic [0:0]   m_axis_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [6:0]   i_cfg_data
);
    import ebh_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SADDR = 8'b0000_0010,
        S_SCMP  = 8'b0000_0100,
        S_RD    = 8'b0000_1000,
        S_UPD   = 8'b0001_0000,
        S_SUM1  = 8'b0010_0000,
        S_SUM2  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state           r_state, n_state;
    logic [ACT_W-1:0] r_act;
    t_req             r_type;
    logic [VAL_W-1:0] r_v;
    logic [VAL_W-1:0] r_bval;
    logic [IDX_W-1:0] r_idx;
    logic [HI_W-1:0]  r_lo, r_hi;
    logic [SQ_W-1:0]  r_sq;
    logic [SUM_W-1:0] r_sum, r_sq_sum;
    logic [CNT_W-1:0] r_total;
    logic [VAL_W-1:0] r_lower;
    logic             r_status;
    logic             r_m_valid;
    logic [IDX_W-1:0] r_o_idx;
    logic [CNT_W-1:0] r_o_total;
    logic [VAL_W-1:0] r_o_lower;
    logic [SUM_W-1:0] r_o_sum, r_o_sq_sum;
    logic             r_o_status;

    t_req             in_type;
    logic [31:0]      in_sample;
    logic [IDX_W-1:0] in_sel;
    logic [VAL_W-1:0] in_bval;
    logic [ACT_W-1:0] act_eff;
    logic [HI_W-1:0]  act_hi;
    logic             sel_ok;
    logic [HI_W-1:0]  mid;
    logic             out_free;
    logic             in_beat;
    t_mem_req         mem_req;
    logic [VAL_W-1:0] bnd_rdata;
    logic [CNT_W-1:0] cnt_rdata;
    logic [CNT_W-1:0] cnt_inc;
    logic [SUM_W-1:0] add_a, add_b, add_res;
    logic [SUM_W:0]   add_full;

    // request unpacking
    assign in_type   = t_req'(s_axis_tuser);
    assign in_sample = s_axis_tdata[31:0];
    assign in_sel    = s_axis_tdata[37:32];
    assign in_bval   = s_axis_tdata[68:38];

    // effective active count, clamped to the legal range
    always_comb begin
        act_eff = r_act;
        if (r_act < ACT_MIN) begin
            act_eff = ACT_MIN;
        end else if (r_act > ACT_TOP) begin
            act_eff = ACT_TOP;
        end
    end
    assign act_hi = HI_W'(act_eff);

    // index check for write (no bucket 0) and read
    always_comb begin
        sel_ok = (HI_W'(in_sel) < act_hi);
        if (in_type == REQ_WRITE && in_sel == '0) begin
            sel_ok = 1'b0;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // search midpoint
    assign mid = HI_W'((r_lo + r_hi) >> 1);

    // shared saturating adder for both running sums
    always_comb begin
        add_a = r_sum;
        add_b = SUM_W'(r_v);
        if (r_state == S_SUM2) begin
            add_a = r_sq_sum;
            add_b = SUM_W'(r_sq);
        end
    end
    assign add_full = {1'b0, add_a} + {1'b0, add_b};
    assign add_res  = add_full[SUM_W] ? SUM_MAX : add_full[SUM_W-1:0];

    assign cnt_inc = (cnt_rdata == CNT_MAX) ? CNT_MAX : cnt_rdata + CNT_W'(1);

    // store access for the current step
    always_comb begin
        mem_req           = '0;
        mem_req.bnd_addr  = r_idx;
        mem_req.cnt_addr  = r_idx;
        mem_req.bnd_wdata = r_bval;
        mem_req.cnt_wdata = cnt_inc;
        case (r_state)
            S_SADDR: begin
                mem_req.bnd_addr = mid[IDX_W-1:0];
            end
            S_RD: begin
                mem_req.bnd_we = (r_type == REQ_WRITE);
            end
            S_UPD: begin
                mem_req.cnt_we = (r_type == REQ_ADD);
            end
            default: begin
            end
        endcase
    end

    ebh_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (mem_req),
        .o_bnd_rdata (bnd_rdata),
        .o_cnt_rdata (cnt_rdata)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    if (in_type == REQ_ADD) begin
                        n_state = S_SADDR;
                    end else if (sel_ok) begin
                        n_state = S_RD;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_SADDR: n_state = (mid == r_lo) ? S_RD : S_SCMP;
            S_SCMP:  n_state = S_SADDR;
            S_RD:    n_state = S_UPD;
            S_UPD:   n_state = (r_type == REQ_ADD) ? S_SUM1 : S_OUT;
            S_SUM1:  n_state = S_SUM2;
            S_SUM2:  n_state = S_OUT;
            S_OUT:   n_state = out_free ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_act     <= ACT_TOP;
            r_sum     <= '0;
            r_sq_sum  <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_act <= i_cfg_data;
            end
            if (r_state == S_SUM1) begin
                r_sum <= add_res;
            end
            if (r_state == S_SUM2) begin
                r_sq_sum <= add_res;
            end
            if (r_state == S_OUT && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_sq <= r_v * r_v;
        case (r_state)
            S_IDLE: begin
                r_type   <= in_type;
                r_v      <= in_sample[31] ? '0 : in_sample[VAL_W-1:0];
                r_bval   <= in_bval;
                r_idx    <= in_sel;
                r_lo     <= '0;
                r_hi     <= act_hi;
                r_total  <= '0;
                r_lower  <= '0;
                r_status <= (in_type != REQ_ADD) && !sel_ok;
            end
            S_SADDR: begin
                if (mid == r_lo) begin
                    r_idx <= r_lo[IDX_W-1:0];
                end
            end
            S_SCMP: begin
                if (bnd_rdata <= r_v) begin
                    r_lo <= mid;
                end else begin
                    r_hi <= mid;
                end
            end
            S_UPD: begin
                r_total  <= (r_type == REQ_ADD) ? cnt_inc : cnt_rdata;
                r_lower  <= (r_type == REQ_WRITE) ? r_bval : bnd_rdata;
                r_status <= (r_type == REQ_UNDEF);
            end
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_o_idx    <= r_idx;
            r_o_total  <= r_total;
            r_o_lower  <= r_lower;
            r_o_sum    <= r_sum;
            r_o_sq_sum <= r_sq_sum;
            r_o_status <= r_status;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {5'b0, r_o_sq_sum, r_o_sum, r_o_lower, r_o_total, r_o_idx};
    assign m_axis_tuser  = r_o_status;

endmodule
